// ===== rtl/rlm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared constants, the frequency table and its builder for the resonant
// low-pass magnitude point block.
// ----------------------------------------------------------------------------
package rlm_pkg;

  // Frequency axis
  localparam int unsigned POINTS    = 256;
  localparam int unsigned ROM_DEPTH = (POINTS < 256) ? POINTS : 256;
  localparam int unsigned ROM_AW    = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
  localparam int unsigned FREQ_W    = 23;   // UQ15.8

  // Field widths
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned CUTOFF_W  = 16;
  localparam int unsigned RES_W     = 17;
  localparam int unsigned MAG_W     = 28;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_HZ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE   = 2'd1;

  // Arithmetic constants
  localparam int unsigned FC_MIN     = 20;
  localparam int unsigned FC_MAX     = 20000;
  localparam int unsigned FC_W       = 15;
  localparam int unsigned RES_ONE    = 65536;
  localparam int unsigned TINY_RATIO = 65;
  localparam int unsigned MAG_MAX    = 268435455;
  localparam int unsigned CUTOFF_RST = 1000;

  // Pipelined divider: 64-bit operands, 28 quotient bits, one bit a stage
  localparam int unsigned DIV_W   = 64;
  localparam int unsigned DIV_Q_W = 28;

  // Pipelined integer square root: 64-bit radicand, one root bit a stage
  localparam int unsigned SQ_W     = 64;
  localparam int unsigned SQ_STEPS = 32;

  localparam logic [63:0] LOG2_1000_Q32 = 64'd42802717582;
  localparam logic [63:0] LN2_Q30       = 64'd744261118;
  localparam logic [63:0] ONE_Q30       = 64'd1 << 30;
  localparam logic [63:0] LO32          = 64'hFFFF_FFFF;

  typedef logic [FREQ_W-1:0] freq_tab_t [ROM_DEPTH];

  // 20 * 1000^(i/(POINTS-1)) in UQ15.8, degree-12 series for 2^frac
  function automatic logic [FREQ_W-1:0] freq_point(input int unsigned i);
    logic [63:0] e;
    logic [63:0] k;
    logic [63:0] y;
    logic [63:0] acc;
    logic [63:0] f;
    e   = (64'(i) * LOG2_1000_Q32) / 64'(POINTS - 1);
    k   = e >> 32;
    y   = (((e & LO32) >> 2) * LN2_Q30) >> 30;
    acc = ONE_Q30;
    acc = ONE_Q30 + ((acc * y) >> 30) / 12;
    acc = ONE_Q30 + ((acc * y) >> 30) / 11;
    acc = ONE_Q30 + ((acc * y) >> 30) / 10;
    acc = ONE_Q30 + ((acc * y) >> 30) / 9;
    acc = ONE_Q30 + ((acc * y) >> 30) / 8;
    acc = ONE_Q30 + ((acc * y) >> 30) / 7;
    acc = ONE_Q30 + ((acc * y) >> 30) / 6;
    acc = ONE_Q30 + ((acc * y) >> 30) / 5;
    acc = ONE_Q30 + ((acc * y) >> 30) / 4;
    acc = ONE_Q30 + ((acc * y) >> 30) / 3;
    acc = ONE_Q30 + ((acc * y) >> 30) / 2;
    acc = ONE_Q30 + ((acc * y) >> 30);
    f   = (((64'd20 * acc) << k[3:0]) + (64'd1 << 21)) >> 22;
    return f[FREQ_W-1:0];
  endfunction

  function automatic freq_tab_t build_freq_tab();
    freq_tab_t tab;
    for (int unsigned i = 0; i < ROM_DEPTH; i++) begin
      tab[i] = freq_point(i);
    end
    return tab;
  endfunction

  localparam freq_tab_t FREQ_TAB = build_freq_tab();

endpackage

// ===== rtl/rlm_divider.sv =====
// ----------------------------------------------------------------------------
// rlm_divider
// Pipelined restoring divider, one quotient bit per stage. The quotient
// must fit DIV_Q_W bits; each stage advances only while en is high.
// ----------------------------------------------------------------------------
module rlm_divider
  import rlm_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [DIV_W-1:0]   num,
  input  logic [DIV_W-1:0]   den,
  output logic [DIV_Q_W-1:0] quo
);

  logic [DIV_W-1:0]   rem_r [DIV_Q_W];
  logic [DIV_W-1:0]   den_r [DIV_Q_W];
  logic [DIV_Q_W-1:0] quo_r [DIV_Q_W];

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
    localparam int unsigned B = DIV_Q_W - 1 - k;
    logic [DIV_W-1:0]   rem_in;
    logic [DIV_W-1:0]   den_in;
    logic [DIV_Q_W-1:0] quo_in;
    logic               take;

    if (k == 0) begin : g_head
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_tail
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // subtract the shifted divisor when it fits
    assign take = (rem_in >> B) >= den_in;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        if (take) begin
          rem_r[k] <= rem_in - (den_in << B);
          quo_r[k] <= quo_in | (DIV_Q_W'(1) << B);
        end else begin
          rem_r[k] <= rem_in;
          quo_r[k] <= quo_in;
        end
      end
    end
  end

  assign quo = quo_r[DIV_Q_W-1];

endmodule

// ===== rtl/rlm_isqrt.sv =====
// ----------------------------------------------------------------------------
// rlm_isqrt
// Pipelined integer square root, floor(sqrt(x)), one root bit per stage.
// Each stage advances only while en is high.
// ----------------------------------------------------------------------------
module rlm_isqrt
  import rlm_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQ_W-1:0]       rad,
  output logic [SQ_STEPS-1:0]   root
);

  logic [SQ_W-1:0] x_r   [SQ_STEPS];
  logic [SQ_W-1:0] res_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SQ_W-1:0] x_in;
    logic [SQ_W-1:0] res_in;
    logic [SQ_W-1:0] trial;

    if (k == 0) begin : g_head
      assign x_in   = rad;
      assign res_in = '0;
    end else begin : g_tail
      assign x_in   = x_r[k-1];
      assign res_in = res_r[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (x_in >= trial) begin
          x_r[k]   <= x_in - trial;
          res_r[k] <= (res_in >> 1) + BIT;
        end else begin
          x_r[k]   <= x_in;
          res_r[k] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_r[SQ_STEPS-1][SQ_STEPS-1:0];

endmodule

// ===== rtl/resonant_lowpass_magnitude_point.sv =====
// ----------------------------------------------------------------------------
// resonant_lowpass_magnitude_point
// Magnitude of a resonant low-pass filter at one point of a log-spaced
// 20 Hz .. 20 kHz axis.
// ----------------------------------------------------------------------------
// Usage: send a point index on in_*; one magnitude (UQ12.16, saturating) comes
// back on out_* with the index echoed, in request order. The block takes one
// request every clock cycle while in_ready is high and holds about 100 in
// flight in the chain of the ratio divider (28 stages), the two square root
// units (32 stages, side by side), the gain dividers (28 stages, side by
// side), eleven stages of table, power, multiply and rounding logic, and the
// output register. A
// two-entry output buffer (output register plus skid) decouples the sides:
// in_ready drops only once both hold a result and out_ready is low, and then
// the whole pipeline holds. Write cutoff_hz (index 0) and resonance_amount
// (index 1) only while no request is in flight; other indexes are dropped.
// ----------------------------------------------------------------------------
module resonant_lowpass_magnitude_point
  import rlm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IDX_W-1:0]     in_point_index,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MAG_W-1:0]     out_magnitude,
  output logic [IDX_W-1:0]     out_point_echo,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RES_W-1:0]     cfg_data
);

  // Sideband that travels next to the long arithmetic units
  typedef struct packed {
    logic             v;
    logic [IDX_W-1:0] idx;
  } sb1_t;

  typedef struct packed {
    logic             v;
    logic [IDX_W-1:0] idx;
    logic [25:0]      r;
    logic             sat;
    logic             big1;
    logic             big2;
  } sb2_t;

  typedef struct packed {
    logic             v;
    logic [IDX_W-1:0] idx;
    logic             tiny;
    logic             sat;
  } sb3_t;

  // ---------------------------------------------------------------- config
  logic [CUTOFF_W-1:0] cutoff_r;
  logic [RES_W-1:0]    res_amt_r;
  logic [FC_W-1:0]     fc_cl;
  logic [RES_W-1:0]    res_cl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r  <= CUTOFF_W'(CUTOFF_RST);
      res_amt_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_CUTOFF_HZ) begin
        cutoff_r <= cfg_data[CUTOFF_W-1:0];
      end else if (cfg_index == CFG_RESONANCE) begin
        res_amt_r <= cfg_data;
      end
    end
  end

  // clamp cutoff to the audio band and resonance to one
  always_comb begin
    if (cutoff_r < CUTOFF_W'(FC_MIN)) begin
      fc_cl = FC_W'(FC_MIN);
    end else if (cutoff_r > CUTOFF_W'(FC_MAX)) begin
      fc_cl = FC_W'(FC_MAX);
    end else begin
      fc_cl = cutoff_r[FC_W-1:0];
    end
  end

  assign res_cl = (res_amt_r > RES_W'(RES_ONE)) ? RES_W'(RES_ONE) : res_amt_r;

  // ---------------------------------------------------------------- flow
  // Every stage advances together; hold everything while the skid is full.
  logic adv;
  logic skid_v_r;

  assign adv      = !skid_v_r;
  assign in_ready = adv;

  // ---------------------------------------------------------------- stage A
  // Clamp the index and look up the point frequency.
  logic [IDX_W-1:0]  idx_cl;
  sb1_t              a_sb_r;
  logic [FREQ_W-1:0] a_f_r;

  assign idx_cl = (in_point_index > IDX_W'(ROM_DEPTH - 1)) ? IDX_W'(ROM_DEPTH - 1)
                                                           : in_point_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_sb_r <= '0;
    end else if (adv) begin
      a_sb_r.v   <= in_valid;
      a_sb_r.idx <= idx_cl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_f_r <= FREQ_TAB[idx_cl[ROM_AW-1:0]];
    end
  end

  // ---------------------------------------------------------------- ratio
  // r = f * 2^8 / fc, UQ10.16
  logic [DIV_Q_W-1:0] q_r_ratio;
  sb1_t               sb1_r [DIV_Q_W];

  rlm_divider u_div_ratio (
    .clk (clk),
    .en  (adv),
    .num (DIV_W'({a_f_r, 8'b0})),
    .den (DIV_W'(fc_cl)),
    .quo (q_r_ratio)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_Q_W; k++) begin
        sb1_r[k] <= '0;
      end
    end else if (adv) begin
      sb1_r[0] <= a_sb_r;
      for (int k = 1; k < DIV_Q_W; k++) begin
        sb1_r[k] <= sb1_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage C
  // r^2 in Q16
  logic [25:0] c_r_r;
  logic [35:0] c_r2_r;
  sb1_t        c_sb_r;
  logic [51:0] r_sq;

  assign r_sq = 52'(q_r_ratio[25:0]) * 52'(q_r_ratio[25:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r_r  <= q_r_ratio[25:0];
      c_r2_r <= r_sq[51:16];
    end
  end

  // ---------------------------------------------------------------- stage D
  // r^4 partial products on halves of r^2
  logic [35:0] d_hh_r;
  logic [35:0] d_hl_r;
  logic [35:0] d_ll_r;
  logic [25:0] d_r_r;
  sb1_t        d_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_hh_r <= 36'(c_r2_r[35:18]) * 36'(c_r2_r[35:18]);
      d_hl_r <= 36'(c_r2_r[35:18]) * 36'(c_r2_r[17:0]);
      d_ll_r <= 36'(c_r2_r[17:0]) * 36'(c_r2_r[17:0]);
      d_r_r  <= c_r_r;
    end
  end

  // ---------------------------------------------------------------- stage E
  // r^4 = (hh*2^36 + 2*hl*2^18 + ll) / 2^16
  logic [71:0] r4_full;
  logic [55:0] e_r4_r;
  logic [25:0] e_r_r;
  sb1_t        e_sb_r;

  assign r4_full = (72'(d_hh_r) << 36) + (72'(d_hl_r) << 19) + 72'(d_ll_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r4_r <= r4_full[71:16];
      e_r_r  <= d_r_r;
    end
  end

  // ---------------------------------------------------------------- stage F
  // r^8 product; a large r^4 saturates r^8 anyway
  logic [63:0] f_m_r;
  logic        f_big4_r;
  logic [55:0] f_r4_r;
  logic [25:0] f_r_r;
  sb1_t        f_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_m_r    <= 64'(e_r4_r[31:0]) * 64'(e_r4_r[31:0]);
      f_big4_r <= |e_r4_r[55:32];
      f_r4_r   <= e_r4_r;
      f_r_r    <= e_r_r;
    end
  end

  // ---------------------------------------------------------------- stage G
  // Prepare both square-root radicands, 1 + r^8 and 1 + r^4, in Q32 form (Q16 when large).
  logic            sat_nxt;
  logic [47:0]     x1;
  logic [56:0]     x2;
  logic            big1_nxt;
  logic            big2_nxt;
  logic [SQ_W-1:0] g_rad1_r;
  logic [SQ_W-1:0] g_rad2_r;
  sb2_t            g_sb_r;

  assign sat_nxt  = f_big4_r | f_m_r[63];
  assign x1       = 48'(f_m_r[62:16]) + 48'(RES_ONE);
  assign x2       = 57'(f_r4_r) + 57'(RES_ONE);
  assign big1_nxt = x1[47];
  assign big2_nxt = |x2[56:47];

  always_ff @(posedge clk) begin
    if (adv) begin
      g_rad1_r <= big1_nxt ? SQ_W'(x1) : (SQ_W'(x1) << 16);
      g_rad2_r <= big2_nxt ? SQ_W'(x2) : (SQ_W'(x2) << 16);
    end
  end

  // Control sideband C..G
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_sb_r <= '0;
      d_sb_r <= '0;
      e_sb_r <= '0;
      f_sb_r <= '0;
      g_sb_r <= '0;
    end else if (adv) begin
      c_sb_r      <= sb1_r[DIV_Q_W-1];
      d_sb_r      <= c_sb_r;
      e_sb_r      <= d_sb_r;
      f_sb_r      <= e_sb_r;
      g_sb_r.v    <= f_sb_r.v;
      g_sb_r.idx  <= f_sb_r.idx;
      g_sb_r.r    <= f_r_r;
      g_sb_r.sat  <= sat_nxt;
      g_sb_r.big1 <= big1_nxt;
      g_sb_r.big2 <= big2_nxt;
    end
  end

  // ---------------------------------------------------------------- roots
  logic [SQ_STEPS-1:0] root1;
  logic [SQ_STEPS-1:0] root2;
  sb2_t                sb2_r [SQ_STEPS];

  rlm_isqrt u_sqrt_lp (
    .clk  (clk),
    .en   (adv),
    .rad  (g_rad1_r),
    .root (root1)
  );

  rlm_isqrt u_sqrt_res (
    .clk  (clk),
    .en   (adv),
    .rad  (g_rad2_r),
    .root (root2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        sb2_r[k] <= '0;
      end
    end else if (adv) begin
      sb2_r[0] <= g_sb_r;
      for (int k = 1; k < SQ_STEPS; k++) begin
        sb2_r[k] <= sb2_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage H
  // Scale the roots back to Q16 and start t = r * sqrt(1 + r^4).
  sb2_t        sb2_o;
  logic [31:0] s_nxt;
  logic [36:0] sq_nxt;
  logic [31:0] h_s_r;
  logic [44:0] h_phi_r;
  logic [43:0] h_plo_r;
  sb3_t        h_sb_r;

  assign sb2_o  = sb2_r[SQ_STEPS-1];
  assign s_nxt  = sb2_o.big1 ? {root1[23:0], 8'b0} : root1;
  assign sq_nxt = sb2_o.big2 ? {root2[28:0], 8'b0} : 37'(root2);

  always_ff @(posedge clk) begin
    if (adv) begin
      h_s_r   <= s_nxt;
      h_phi_r <= 45'(sb2_o.r) * 45'(sq_nxt[36:18]);
      h_plo_r <= 44'(sb2_o.r) * 44'(sq_nxt[17:0]);
    end
  end

  // ---------------------------------------------------------------- stage I
  logic [62:0] i_t_r;
  logic [31:0] i_s_r;
  sb3_t        i_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      i_t_r <= (63'(h_phi_r) << 18) + 63'(h_plo_r);
      i_s_r <= h_s_r;
    end
  end

  // ---------------------------------------------------------------- stage J
  // Rounded dividends; a tiny ratio skips the resonant term.
  logic [DIV_W-1:0] j_num1_r;
  logic [DIV_W-1:0] j_den1_r;
  logic [DIV_W-1:0] j_num2_r;
  logic [DIV_W-1:0] j_den2_r;
  sb3_t             j_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      j_num1_r <= (DIV_W'(1) << 32) + DIV_W'(i_s_r >> 1);
      j_den1_r <= DIV_W'(i_s_r);
      if (i_sb_r.tiny) begin
        j_num2_r <= '0;
        j_den2_r <= DIV_W'(1);
      end else begin
        j_num2_r <= (DIV_W'(res_cl) << 34) + DIV_W'(i_t_r >> 1);
        j_den2_r <= DIV_W'(i_t_r);
      end
    end
  end

  // Control sideband H..J
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_sb_r <= '0;
      i_sb_r <= '0;
      j_sb_r <= '0;
    end else if (adv) begin
      h_sb_r.v    <= sb2_o.v;
      h_sb_r.idx  <= sb2_o.idx;
      h_sb_r.tiny <= sb2_o.r <= 26'(TINY_RATIO);
      h_sb_r.sat  <= sb2_o.sat;
      i_sb_r      <= h_sb_r;
      j_sb_r      <= i_sb_r;
    end
  end

  // ---------------------------------------------------------------- gains
  logic [DIV_Q_W-1:0] q_lp;
  logic [DIV_Q_W-1:0] q_bump;
  sb3_t               sb3_r [DIV_Q_W];

  rlm_divider u_div_lp (
    .clk (clk),
    .en  (adv),
    .num (j_num1_r),
    .den (j_den1_r),
    .quo (q_lp)
  );

  rlm_divider u_div_bump (
    .clk (clk),
    .en  (adv),
    .num (j_num2_r),
    .den (j_den2_r),
    .quo (q_bump)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_Q_W; k++) begin
        sb3_r[k] <= '0;
      end
    end else if (adv) begin
      sb3_r[0] <= j_sb_r;
      for (int k = 1; k < DIV_Q_W; k++) begin
        sb3_r[k] <= sb3_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage K
  // Drop the low-pass gain on saturation, add one to the bump.
  sb3_t        sb3_o;
  logic [16:0] k_lp_r;
  logic [28:0] k_g_r;
  sb3_t        k_sb_r;

  assign sb3_o = sb3_r[DIV_Q_W-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      k_lp_r <= sb3_o.sat ? '0 : q_lp[16:0];
      k_g_r  <= 29'(RES_ONE) + (sb3_o.tiny ? 29'd0 : 29'(q_bump));
    end
  end

  // ---------------------------------------------------------------- stage L
  logic [45:0] l_prod_r;
  sb3_t        l_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      l_prod_r <= 46'(k_lp_r) * 46'(k_g_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_sb_r <= '0;
      l_sb_r <= '0;
    end else if (adv) begin
      k_sb_r <= sb3_o;
      l_sb_r <= k_sb_r;
    end
  end

  // ---------------------------------------------------------------- output
  // Round to UQ12.16 and saturate.
  logic [46:0]      mag_sum;
  logic [MAG_W-1:0] mag_nxt;
  logic             exit_v;

  assign mag_sum = 47'(l_prod_r) + 47'(32768);
  assign mag_nxt = (mag_sum[46:16] > 31'(MAG_MAX)) ? MAG_W'(MAG_MAX) : mag_sum[43:16];
  assign exit_v  = adv && l_sb_r.v;

  logic             out_v_r;
  logic [MAG_W-1:0] out_mag_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [MAG_W-1:0] skid_mag_r;
  logic [IDX_W-1:0] skid_idx_r;

  // Output register in front, skid behind it; refill from skid first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= exit_v;
      end
    end else if (exit_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_v_r) begin
      if (skid_v_r) begin
        out_mag_r <= skid_mag_r;
        out_idx_r <= skid_idx_r;
      end else begin
        out_mag_r <= mag_nxt;
        out_idx_r <= l_sb_r.idx;
      end
    end else if (exit_v) begin
      skid_mag_r <= mag_nxt;
      skid_idx_r <= l_sb_r.idx;
    end
  end

  assign out_valid      = out_v_r;
  assign out_magnitude  = out_mag_r;
  assign out_point_echo = out_idx_r;

endmodule
